// ===== rtl/core/bilinear_height_sample_top_macros.svh =====
// ---------------------------------------------------------------------------
// Bilinear height sampler assertion macros
// Shared clocked assertion forms for the sampler's checkers.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_HEIGHT_SAMPLE_TOP_MACROS_SVH
`define BILINEAR_HEIGHT_SAMPLE_TOP_MACROS_SVH

// Clocked assertion, masked while reset is high
`define BHS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that must also hold while reset is high
`define BHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bhs_pkg.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler package
// Widths, codes and inter-module structs of the sampler pipeline.
// ---------------------------------------------------------------------------
package bhs_pkg;

   localparam int MAX_DIM        = 256;
   localparam int DIM_BITS       = $clog2(MAX_DIM);
   localparam int CFG_DIM_BITS   = 9;
   localparam int WEIGHT_BITS    = 8;
   localparam int FRAC_BITS      = 15;
   localparam int POS_BITS       = 16;
   localparam int TEXEL_BITS     = 16;
   localparam int ELEV_BITS      = 24;
   localparam int SIZE_BITS      = DIM_BITS + 1;
   localparam int OFFS_BITS      = FRAC_BITS + 1;
   localparam int FIX_BITS       = OFFS_BITS + DIM_BITS;
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_BITS  = 2;
   localparam int BANK_ADDR_BITS = 2 * (DIM_BITS - 1);
   localparam int BANK_DEPTH     = MAX_DIM * MAX_DIM / NUM_BANKS;
   localparam int WPROD_BITS     = 2 * WEIGHT_BITS + 1;
   localparam int ACC_BITS       = TEXEL_BITS + WPROD_BITS + 1;
   localparam int OUT_SHIFT      = 2 * WEIGHT_BITS - 8;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic signed [POS_BITS-1:0] POS_ONE = POS_BITS'(1 << (FRAC_BITS - 1));
   localparam logic [OFFS_BITS-1:0] OFFS_FULL = OFFS_BITS'(1 << FRAC_BITS);
   localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS + 1)'(1 << WEIGHT_BITS);

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register indexes
   localparam logic [1:0] REG_MAP_PRESENT = 2'd0;
   localparam logic [1:0] REG_MAP_WIDTH   = 2'd1;
   localparam logic [1:0] REG_MAP_HEIGHT  = 2'd2;

   typedef struct packed {
      logic                present;
      logic [DIM_BITS-1:0] w_last;
      logic [DIM_BITS-1:0] h_last;
   } cfg_type;

   typedef struct packed {
      logic                                     wr_en;
      logic [BANK_SEL_BITS-1:0]                 wr_bank;
      logic [BANK_ADDR_BITS-1:0]                wr_addr;
      logic [TEXEL_BITS-1:0]                    wr_data;
      logic                                     rd_en;
      logic [NUM_BANKS-1:0][BANK_ADDR_BITS-1:0] rd_addr;
   } store_req_type;

   // corner_bank order: [i0][j0], [i0][j1], [i1][j0], [i1][j1]
   typedef struct packed {
      logic                                    valid;
      logic                                    sample;
      logic [WEIGHT_BITS-1:0]                  alpha;
      logic [WEIGHT_BITS-1:0]                  beta;
      logic [NUM_BANKS-1:0][BANK_SEL_BITS-1:0] corner_bank;
   } blend_req_type;

   typedef logic [NUM_BANKS-1:0][TEXEL_BITS-1:0] bank_data_type;

endpackage

// ===== rtl/core/bilinear_height_sample_top.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler
// Heightmap texel store with a pipelined bilinear sample path.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                   Per item
//   req_     in   tuser command; tdata position / texel     write or sample
//   rsp_     out  tdata elevation (Q16.8)                   one per sample
//   csr_     io   map_present, map_width, map_height        register access
//
// One item is taken every cycle while rsp_ is not stalled. A sample's result
// passes through the registers capture, clamp, scale, bank read, corner
// select and weights, multiply and sum before it shows on rsp_.
// Reset clears all valid bits and the CSR registers; the texel store is not
// cleared and needs no sweep.
// When rsp_ holds a result that is not taken, the whole pipeline and the
// bank reads freeze, and req_tready drops in the same cycle.
// ---------------------------------------------------------------------------
module bilinear_height_sample_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] pos_x, [31:16] pos_y, [39:32] texel_i, [47:40] texel_j,
   // [63:48] texel_value
   input  logic [63:0]                        req_tdata,
   // [0] command
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [23:0] elevation
   output logic [23:0]                        rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bhs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bhs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bhs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   bhs_pkg::cfg_type        cfg;
   bhs_pkg::store_req_type  store_req;
   bhs_pkg::blend_req_type  blend_req;
   bhs_pkg::bank_data_type  rd_data;
   logic                    advance;
   logic                    req_accept;
   logic                    rsp_valid;

   // advance whenever the result register is empty or being taken
   assign advance    = !rsp_valid || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;
   assign rsp_tvalid = rsp_valid;

   bhs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bhs_coord u_coord (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cfg             (cfg),
      .req_accept      (req_accept),
      .req_command     (req_tuser),
      .req_pos_x       (req_tdata[15:0]),
      .req_pos_y       (req_tdata[31:16]),
      .req_texel_i     (req_tdata[39:32]),
      .req_texel_j     (req_tdata[47:40]),
      .req_texel_value (req_tdata[63:48]),
      .store_req       (store_req),
      .blend_req       (blend_req)
   );

   bhs_texel_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   bhs_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .map_present   (cfg.present),
      .blend_req     (blend_req),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_elevation (rsp_tdata)
   );

endmodule

// ===== rtl/core/bhs_csr.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler registers
// APB-style register file: map_present, map_width, map_height.
// ---------------------------------------------------------------------------
module bhs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bhs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bhs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bhs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output bhs_pkg::cfg_type                   cfg
);

   logic                                present_ff;
   logic [bhs_pkg::CFG_DIM_BITS-1:0]    width_ff;
   logic [bhs_pkg::CFG_DIM_BITS-1:0]    height_ff;
   logic                                wr_strobe;
   logic [1:0]                          reg_index;

   function automatic logic [bhs_pkg::DIM_BITS-1:0] last_index(
      input logic [bhs_pkg::CFG_DIM_BITS-1:0] raw
   );
      logic [bhs_pkg::CFG_DIM_BITS-1:0] less;
      begin
         less = raw - bhs_pkg::CFG_DIM_BITS'(1);
         if (raw == '0) begin
            last_index = '0;
         end else if (raw > bhs_pkg::CFG_DIM_BITS'(bhs_pkg::MAX_DIM)) begin
            last_index = bhs_pkg::DIM_BITS'(bhs_pkg::MAX_DIM - 1);
         end else begin
            last_index = less[bhs_pkg::DIM_BITS-1:0];
         end
      end
   endfunction

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         width_ff   <= bhs_pkg::CFG_DIM_BITS'(256);
         height_ff  <= bhs_pkg::CFG_DIM_BITS'(256);
      end else if (wr_strobe) begin
         case (reg_index)
            bhs_pkg::REG_MAP_PRESENT: present_ff <= csr_pwdata[0];
            bhs_pkg::REG_MAP_WIDTH:   width_ff   <= csr_pwdata[bhs_pkg::CFG_DIM_BITS-1:0];
            bhs_pkg::REG_MAP_HEIGHT:  height_ff  <= csr_pwdata[bhs_pkg::CFG_DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         bhs_pkg::REG_MAP_PRESENT: csr_prdata = bhs_pkg::CSR_DATA_BITS'(present_ff);
         bhs_pkg::REG_MAP_WIDTH:   csr_prdata = bhs_pkg::CSR_DATA_BITS'(width_ff);
         bhs_pkg::REG_MAP_HEIGHT:  csr_prdata = bhs_pkg::CSR_DATA_BITS'(height_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.present = present_ff;
      cfg.w_last  = last_index(width_ff);
      cfg.h_last  = last_index(height_ff);
   end

endmodule

// ===== rtl/core/bhs_coord.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler coordinate front end
// Captures items, clamps and scales positions, and issues store accesses.
// ---------------------------------------------------------------------------
module bhs_coord (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  bhs_pkg::cfg_type                   cfg,
   input  logic                               req_accept,
   input  logic                               req_command,
   input  logic [bhs_pkg::POS_BITS-1:0]       req_pos_x,
   input  logic [bhs_pkg::POS_BITS-1:0]       req_pos_y,
   input  logic [bhs_pkg::DIM_BITS-1:0]       req_texel_i,
   input  logic [bhs_pkg::DIM_BITS-1:0]       req_texel_j,
   input  logic [bhs_pkg::TEXEL_BITS-1:0]     req_texel_value,
   output bhs_pkg::store_req_type             store_req,
   output bhs_pkg::blend_req_type             blend_req
);

   typedef struct packed {
      logic                           command;
      logic [bhs_pkg::DIM_BITS-1:0]   texel_i;
      logic [bhs_pkg::DIM_BITS-1:0]   texel_j;
      logic [bhs_pkg::TEXEL_BITS-1:0] texel_value;
   } carry_type;

   logic [2:0]                          valid_ff;
   logic [2:0]                          valid_in;
   carry_type                           carry0_ff;
   carry_type                           carry0_in;
   carry_type                           carry1_ff;
   carry_type                           carry2_ff;
   logic signed [bhs_pkg::POS_BITS-1:0] pos_x0_ff;
   logic signed [bhs_pkg::POS_BITS-1:0] pos_y0_ff;
   logic [bhs_pkg::OFFS_BITS-1:0]       offs_x1_ff;
   logic [bhs_pkg::OFFS_BITS-1:0]       offs_x1_in;
   logic [bhs_pkg::OFFS_BITS-1:0]       flip_y1_ff;
   logic [bhs_pkg::OFFS_BITS-1:0]       flip_y1_in;
   logic [bhs_pkg::FIX_BITS-1:0]        ufix2_ff;
   logic [bhs_pkg::FIX_BITS-1:0]        ufix2_in;
   logic [bhs_pkg::FIX_BITS-1:0]        vfix2_ff;
   logic [bhs_pkg::FIX_BITS-1:0]        vfix2_in;

   logic [bhs_pkg::SIZE_BITS-1:0]                 w_eff;
   logic [bhs_pkg::SIZE_BITS-1:0]                 h_eff;
   logic [bhs_pkg::OFFS_BITS+bhs_pkg::SIZE_BITS-1:0] uprod;
   logic [bhs_pkg::OFFS_BITS+bhs_pkg::SIZE_BITS-1:0] vprod;
   logic [bhs_pkg::SIZE_BITS-1:0]                 ui;
   logic [bhs_pkg::SIZE_BITS-1:0]                 vi;
   logic                                          u_lt;
   logic                                          v_lt;
   logic [bhs_pkg::DIM_BITS-1:0]                  i0;
   logic [bhs_pkg::DIM_BITS-1:0]                  i1;
   logic [bhs_pkg::DIM_BITS-1:0]                  j0;
   logic [bhs_pkg::DIM_BITS-1:0]                  j1;
   logic [1:0][bhs_pkg::DIM_BITS-1:0]             i_sel;
   logic [1:0][bhs_pkg::DIM_BITS-1:0]             j_sel;

   function automatic logic [bhs_pkg::OFFS_BITS-1:0] clamp_offset(
      input logic signed [bhs_pkg::POS_BITS-1:0] p
   );
      logic signed [bhs_pkg::POS_BITS:0] shifted;
      begin
         shifted = p + bhs_pkg::POS_ONE;
         if (p < -bhs_pkg::POS_ONE) begin
            clamp_offset = '0;
         end else if (p > bhs_pkg::POS_ONE) begin
            clamp_offset = bhs_pkg::OFFS_FULL;
         end else begin
            clamp_offset = bhs_pkg::OFFS_BITS'(shifted);
         end
      end
   endfunction

   // stage valids: capture, clamp, scale
   assign valid_in = {valid_ff[1:0], req_accept};

   always_comb begin
      carry0_in.command     = req_command;
      carry0_in.texel_i     = req_texel_i;
      carry0_in.texel_j     = req_texel_j;
      carry0_in.texel_value = req_texel_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // clamp to [-1, 1] and move to [0, 2]; v runs opposite to y
   always_comb begin
      offs_x1_in = clamp_offset(pos_x0_ff);
      flip_y1_in = bhs_pkg::OFFS_FULL - clamp_offset(pos_y0_ff);
   end

   always_comb begin
      w_eff    = {1'b0, cfg.w_last} + bhs_pkg::SIZE_BITS'(1);
      h_eff    = {1'b0, cfg.h_last} + bhs_pkg::SIZE_BITS'(1);
      uprod    = offs_x1_ff * w_eff;
      vprod    = flip_y1_ff * h_eff;
      ufix2_in = uprod[bhs_pkg::FIX_BITS-1:0];
      vfix2_in = vprod[bhs_pkg::FIX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         carry0_ff  <= carry0_in;
         pos_x0_ff  <= req_pos_x;
         pos_y0_ff  <= req_pos_y;
         carry1_ff  <= carry0_ff;
         offs_x1_ff <= offs_x1_in;
         flip_y1_ff <= flip_y1_in;
         carry2_ff  <= carry1_ff;
         ufix2_ff   <= ufix2_in;
         vfix2_ff   <= vfix2_in;
      end
   end

   // corners, clamped to the last texel
   always_comb begin
      ui   = ufix2_ff[bhs_pkg::FIX_BITS-1:bhs_pkg::FRAC_BITS];
      vi   = vfix2_ff[bhs_pkg::FIX_BITS-1:bhs_pkg::FRAC_BITS];
      u_lt = ui < {1'b0, cfg.w_last};
      v_lt = vi < {1'b0, cfg.h_last};
      i0   = u_lt ? ui[bhs_pkg::DIM_BITS-1:0] : cfg.w_last;
      i1   = u_lt ? ui[bhs_pkg::DIM_BITS-1:0] + bhs_pkg::DIM_BITS'(1) : cfg.w_last;
      j0   = v_lt ? vi[bhs_pkg::DIM_BITS-1:0] : cfg.h_last;
      j1   = v_lt ? vi[bhs_pkg::DIM_BITS-1:0] + bhs_pkg::DIM_BITS'(1) : cfg.h_last;
   end

   // each parity bank reads the corner index of its own parity
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         i_sel[p] = (i0[0] == p[0]) ? i0 : i1;
         j_sel[p] = (j0[0] == p[0]) ? j0 : j1;
      end
   end

   always_comb begin
      store_req.wr_en   = valid_ff[2] && (carry2_ff.command == bhs_pkg::CMD_WRITE) && advance;
      store_req.wr_bank = {carry2_ff.texel_i[0], carry2_ff.texel_j[0]};
      store_req.wr_addr = {carry2_ff.texel_i[bhs_pkg::DIM_BITS-1:1],
                           carry2_ff.texel_j[bhs_pkg::DIM_BITS-1:1]};
      store_req.wr_data = carry2_ff.texel_value;
      store_req.rd_en   = advance;
      for (int b = 0; b < bhs_pkg::NUM_BANKS; b++) begin
         store_req.rd_addr[b] = {i_sel[b / 2][bhs_pkg::DIM_BITS-1:1],
                                 j_sel[b % 2][bhs_pkg::DIM_BITS-1:1]};
      end
   end

   always_comb begin
      blend_req.valid          = valid_ff[2];
      blend_req.sample         = carry2_ff.command == bhs_pkg::CMD_SAMPLE;
      blend_req.alpha          = ufix2_ff[bhs_pkg::FRAC_BITS-1 -: bhs_pkg::WEIGHT_BITS];
      blend_req.beta           = vfix2_ff[bhs_pkg::FRAC_BITS-1 -: bhs_pkg::WEIGHT_BITS];
      blend_req.corner_bank[0] = {i0[0], j0[0]};
      blend_req.corner_bank[1] = {i0[0], j1[0]};
      blend_req.corner_bank[2] = {i1[0], j0[0]};
      blend_req.corner_bank[3] = {i1[0], j1[0]};
   end

endmodule

// ===== rtl/core/bhs_texel_store.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler texel store
// Four parity banks, one write and one registered read per bank per cycle;
// reads are taken only while rd_en is high.
module bhs_texel_store (
   input  logic                    clock,
   input  bhs_pkg::store_req_type  store_req,
   output bhs_pkg::bank_data_type  rd_data
);

   logic [bhs_pkg::TEXEL_BITS-1:0] rd_data_ff [bhs_pkg::NUM_BANKS];

   for (genvar b = 0; b < bhs_pkg::NUM_BANKS; b++) begin : g_bank
      logic [bhs_pkg::TEXEL_BITS-1:0] mem [bhs_pkg::BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (store_req.wr_en && (store_req.wr_bank == bhs_pkg::BANK_SEL_BITS'(b))) begin
            mem[store_req.wr_addr] <= store_req.wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (store_req.rd_en) begin
            rd_data_ff[b] <= mem[store_req.rd_addr[b]];
         end
      end
   end

   always_comb begin
      for (int b = 0; b < bhs_pkg::NUM_BANKS; b++) begin
         rd_data[b] = rd_data_ff[b];
      end
   end

endmodule

// ===== rtl/core/bhs_blend.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler blend back end
// Picks the corners, forms weights, multiplies, sums and holds the result.
// ---------------------------------------------------------------------------
module bhs_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              map_present,
   input  bhs_pkg::blend_req_type            blend_req,
   input  bhs_pkg::bank_data_type            rd_data,
   output logic                              rsp_valid,
   output logic [bhs_pkg::ELEV_BITS-1:0]     rsp_elevation
);

   logic                                   valid3_ff;
   bhs_pkg::blend_req_type                 info3_ff;
   logic                                   valid4_ff;
   logic signed [bhs_pkg::TEXEL_BITS-1:0]  tex4_ff [bhs_pkg::NUM_BANKS];
   logic signed [bhs_pkg::TEXEL_BITS-1:0]  tex4_in [bhs_pkg::NUM_BANKS];
   logic [bhs_pkg::WPROD_BITS-1:0]         wgt4_ff [bhs_pkg::NUM_BANKS];
   logic [bhs_pkg::WPROD_BITS-1:0]         wgt4_in [bhs_pkg::NUM_BANKS];
   logic                                   valid5_ff;
   logic signed [bhs_pkg::ACC_BITS-1:0]    prod5_ff [bhs_pkg::NUM_BANKS];
   logic signed [bhs_pkg::ACC_BITS-1:0]    prod5_in [bhs_pkg::NUM_BANKS];
   logic                                   rsp_valid_ff;
   logic [bhs_pkg::ELEV_BITS-1:0]          elev_ff;
   logic [bhs_pkg::ELEV_BITS-1:0]          elev_in;

   logic [bhs_pkg::WEIGHT_BITS:0]          wa [2];
   logic [bhs_pkg::WEIGHT_BITS:0]          wb [2];
   logic [2*bhs_pkg::WEIGHT_BITS+1:0]      wfull [bhs_pkg::NUM_BANKS];
   logic signed [bhs_pkg::ACC_BITS-1:0]    acc;

   // writes leave the pipeline here
   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff    <= 1'b0;
         valid4_ff    <= 1'b0;
         valid5_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid3_ff    <= blend_req.valid && blend_req.sample;
         valid4_ff    <= valid3_ff;
         valid5_ff    <= valid4_ff;
         rsp_valid_ff <= valid5_ff;
      end
   end

   // index 0 is the (1 - w) side, index 1 the w side
   always_comb begin
      wa[0] = bhs_pkg::WEIGHT_ONE - {1'b0, info3_ff.alpha};
      wa[1] = {1'b0, info3_ff.alpha};
      wb[0] = bhs_pkg::WEIGHT_ONE - {1'b0, info3_ff.beta};
      wb[1] = {1'b0, info3_ff.beta};
      for (int k = 0; k < bhs_pkg::NUM_BANKS; k++) begin
         tex4_in[k] = $signed(rd_data[info3_ff.corner_bank[k]]);
         wfull[k]   = wa[k / 2] * wb[k % 2];
         wgt4_in[k] = wfull[k][bhs_pkg::WPROD_BITS-1:0];
      end
   end

   always_comb begin
      for (int k = 0; k < bhs_pkg::NUM_BANKS; k++) begin
         prod5_in[k] = tex4_ff[k] * $signed({1'b0, wgt4_ff[k]});
      end
   end

   // floor shift to Q16.8 is a plain bit slice of the two's complement sum
   always_comb begin
      acc     = prod5_ff[0] + prod5_ff[1] + prod5_ff[2] + prod5_ff[3];
      elev_in = map_present ? acc[bhs_pkg::OUT_SHIFT +: bhs_pkg::ELEV_BITS] : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info3_ff <= blend_req;
         tex4_ff  <= tex4_in;
         wgt4_ff  <= wgt4_in;
         prod5_ff <= prod5_in;
         elev_ff  <= elev_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elevation = elev_ff;

endmodule

// ===== rtl/core/bhs_checker.sv =====
// ---------------------------------------------------------------------------
// Bilinear height sampler port checker
// Watches the stream ports of the sampler top level over time.
// ---------------------------------------------------------------------------
`include "bilinear_height_sample_top_macros.svh"

module bhs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `BHS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")

   `BHS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   `BHS_ASSERT(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "item taken while output stalled")

   `BHS_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "input refused with empty output")

endmodule

bind bilinear_height_sample_top bhs_checker u_bhs_checker (.*);

// ===== tb/bilinear_height_sample_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear height sampler testbench
// Streams texel writes and sample positions into the sampler and checks
// every elevation against an in-bench bilinear predictor. Runs a directed
// set, then random traffic under several map sizes and idle profiles.
// ---------------------------------------------------------------------------
module bilinear_height_sample_top_test;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_PAUSE    = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SEGMENT_ITEMS  = 63;
   localparam int POS_UNIT       = int'(bhs_pkg::POS_ONE);
   localparam int unsigned FRAC_MASK = (1 << bhs_pkg::FRAC_BITS) - 1;
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic                                  cmd;
      logic signed [bhs_pkg::POS_BITS-1:0]   pos_x;
      logic signed [bhs_pkg::POS_BITS-1:0]   pos_y;
      logic [7:0]                            tex_i;
      logic [7:0]                            tex_j;
      logic signed [bhs_pkg::TEXEL_BITS-1:0] tex_val;
   } height_item_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [63:0]                       req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [23:0]                       rsp_tdata;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [bhs_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [bhs_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [bhs_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   // predictor state
   logic signed [bhs_pkg::TEXEL_BITS-1:0] elevation_map [0:bhs_pkg::MAX_DIM-1][0:bhs_pkg::MAX_DIM-1];
   logic                                  cfg_present = 1'b0;
   logic [bhs_pkg::CFG_DIM_BITS-1:0]      cfg_width   = 9'd256;
   logic [bhs_pkg::CFG_DIM_BITS-1:0]      cfg_height  = 9'd256;
   logic [bhs_pkg::ELEV_BITS-1:0]         elevation_due [$];

   // stimulus side
   height_item_type pending_items [$];
   height_item_type bus_item;
   bit              filled [0:bhs_pkg::MAX_DIM-1][0:bhs_pkg::MAX_DIM-1];
   int unsigned     send_idle_pct = 22;
   int unsigned     recv_idle_pct = 80;
   int unsigned     n_writes = 0, n_samples = 0, n_results = 0, n_csr = 0;
   int unsigned     n_fail = 0;
   int unsigned     stall_cycles = 0;

   bilinear_height_sample_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned eff_dim(input logic [bhs_pkg::CFG_DIM_BITS-1:0] d);
      if (d == '0) return 1;
      if (d > bhs_pkg::CFG_DIM_BITS'(bhs_pkg::MAX_DIM)) return bhs_pkg::MAX_DIM;
      return 32'(d);
   endfunction

   function automatic int unsigned clamp_offset(input logic signed [bhs_pkg::POS_BITS-1:0] p);
      int q;
      q = int'(p);
      if (q < -POS_UNIT) q = -POS_UNIT;
      if (q > POS_UNIT) q = POS_UNIT;
      return unsigned'(q + POS_UNIT);
   endfunction

   // corners and Q0.8 weights of a position under the current map size
   function automatic void locate(input logic signed [bhs_pkg::POS_BITS-1:0] px, py,
                                  output int unsigned i0, i1, j0, j1, a, b);
      int unsigned w, h, uf, vf, ui, vi;
      w  = eff_dim(cfg_width);
      h  = eff_dim(cfg_height);
      uf = clamp_offset(px) * w;
      vf = (32'(bhs_pkg::OFFS_FULL) - clamp_offset(py)) * h;
      ui = uf >> bhs_pkg::FRAC_BITS;
      vi = vf >> bhs_pkg::FRAC_BITS;
      a  = (uf & FRAC_MASK) >> (bhs_pkg::FRAC_BITS - bhs_pkg::WEIGHT_BITS);
      b  = (vf & FRAC_MASK) >> (bhs_pkg::FRAC_BITS - bhs_pkg::WEIGHT_BITS);
      i0 = (ui < w - 1) ? ui : w - 1;
      i1 = (ui + 1 < w - 1) ? ui + 1 : w - 1;
      j0 = (vi < h - 1) ? vi : h - 1;
      j1 = (vi + 1 < h - 1) ? vi + 1 : h - 1;
   endfunction

   function automatic logic [bhs_pkg::ELEV_BITS-1:0] predict_elevation(
         input logic signed [bhs_pkg::POS_BITS-1:0] px, py);
      int unsigned i0, i1, j0, j1, a, b;
      longint      wa, wb, one, acc;
      if (!cfg_present) return '0;
      locate(px, py, i0, i1, j0, j1, a, b);
      wa  = longint'(a);
      wb  = longint'(b);
      one = longint'(1) << bhs_pkg::WEIGHT_BITS;
      acc = longint'(elevation_map[i0][j0]) * (one - wa) * (one - wb)
          + longint'(elevation_map[i0][j1]) * (one - wa) * wb
          + longint'(elevation_map[i1][j0]) * wa * (one - wb)
          + longint'(elevation_map[i1][j1]) * wa * wb;
      return bhs_pkg::ELEV_BITS'(acc >>> bhs_pkg::OUT_SHIFT);
   endfunction

   task automatic flag_mismatch(input string what, input logic [bhs_pkg::ELEV_BITS-1:0] got,
                                input logic [bhs_pkg::ELEV_BITS-1:0] want);
      $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
      n_fail++;
   endtask

   // driver: hold the item until taken, then load the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (bus_item.cmd == bhs_pkg::CMD_WRITE)
               elevation_map[bus_item.tex_i][bus_item.tex_j] = bus_item.tex_val;
            else
               elevation_due = {elevation_due,
                                predict_elevation(bus_item.pos_x, bus_item.pos_y)};
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= bus_item.cmd;
               req_tdata  <= {bus_item.tex_val, bus_item.tex_j, bus_item.tex_i,
                              bus_item.pos_y, bus_item.pos_x};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (elevation_due.size() == 0)
               flag_mismatch("elevation with nothing expected", rsp_tdata, 'x);
            else if (rsp_tdata !== elevation_due[0])
               flag_mismatch("elevation", rsp_tdata, elevation_due.pop_front());
            else
               void'(elevation_due.pop_front());
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, stall_cycles);
         $display("bilinear_height_sample_top_test NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic csr_write(input logic [1:0] idx,
                            input logic [bhs_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bhs_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         bhs_pkg::REG_MAP_PRESENT: cfg_present = value[0];
         bhs_pkg::REG_MAP_WIDTH:   cfg_width   = value[bhs_pkg::CFG_DIM_BITS-1:0];
         bhs_pkg::REG_MAP_HEIGHT:  cfg_height  = value[bhs_pkg::CFG_DIM_BITS-1:0];
         default: ;
      endcase
      n_csr++;
   endtask

   task automatic set_map(input logic present,
                          input logic [bhs_pkg::CFG_DIM_BITS-1:0] w, h);
      csr_write(bhs_pkg::REG_MAP_PRESENT, bhs_pkg::CSR_DATA_BITS'(present));
      csr_write(bhs_pkg::REG_MAP_WIDTH, bhs_pkg::CSR_DATA_BITS'(w));
      csr_write(bhs_pkg::REG_MAP_HEIGHT, bhs_pkg::CSR_DATA_BITS'(h));
   endtask

   task automatic queue_write(input int unsigned i, j, input logic signed [15:0] v);
      height_item_type it;
      it.cmd     = bhs_pkg::CMD_WRITE;
      it.pos_x   = bhs_pkg::POS_BITS'($urandom);
      it.pos_y   = bhs_pkg::POS_BITS'($urandom);
      it.tex_i   = 8'(i);
      it.tex_j   = 8'(j);
      it.tex_val = v;
      pending_items = {pending_items, it};
      filled[i][j] = 1'b1;
      n_writes++;
   endtask

   // load any corner not yet written, then the sample itself
   task automatic queue_sample(input logic signed [bhs_pkg::POS_BITS-1:0] px, py);
      height_item_type it;
      int unsigned     i0, i1, j0, j1, a, b;
      locate(px, py, i0, i1, j0, j1, a, b);
      if (!filled[i0][j0]) queue_write(i0, j0, 16'($urandom));
      if (!filled[i0][j1]) queue_write(i0, j1, 16'($urandom));
      if (!filled[i1][j0]) queue_write(i1, j0, 16'($urandom));
      if (!filled[i1][j1]) queue_write(i1, j1, 16'($urandom));
      it.cmd     = bhs_pkg::CMD_SAMPLE;
      it.pos_x   = px;
      it.pos_y   = py;
      it.tex_i   = 8'($urandom);
      it.tex_j   = 8'($urandom);
      it.tex_val = bhs_pkg::TEXEL_BITS'($urandom);
      pending_items = {pending_items, it};
      n_samples++;
   endtask

   function automatic logic signed [bhs_pkg::POS_BITS-1:0] rand_pos();
      case ($urandom_range(9))
         0, 1, 2, 3: return bhs_pkg::POS_BITS'($urandom);
         4, 5, 6:    return bhs_pkg::POS_BITS'(int'($urandom_range(2 * POS_UNIT)) - POS_UNIT);
         7:          return -bhs_pkg::POS_ONE;
         8:          return bhs_pkg::POS_ONE;
         default: begin
            case ($urandom_range(2))
               0:       return 16'sh8000;
               1:       return 16'sh7fff;
               default: return 16'sh0000;
            endcase
         end
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || elevation_due.size() != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   initial begin
      int unsigned w, h, seg_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no map loaded after reset: sample must read zero
      queue_sample(16'sh8000, 16'sh7fff);
      wait_idle();

      set_map(1'b1, 9'd4, 9'd3);
      csr_write(REG_SPARE, $urandom);
      for (int unsigned i = 0; i < 4; i++) begin
         for (int unsigned j = 0; j < 3; j++) begin
            case ((i * 3 + j) % 4)
               0:       queue_write(i, j, 16'sh7fff);
               1:       queue_write(i, j, 16'sh8000);
               2:       queue_write(i, j, 16'sh0000);
               default: queue_write(i, j, 16'($urandom));
            endcase
         end
      end
      queue_sample(16'sh8000, 16'sh8000);
      queue_sample(16'sh7fff, 16'sh7fff);
      queue_sample(bhs_pkg::POS_ONE, bhs_pkg::POS_ONE);
      queue_sample(-bhs_pkg::POS_ONE, -bhs_pkg::POS_ONE);
      queue_sample(16'sh0000, 16'sh0000);
      queue_sample(16'sd8191, -16'sd5000);
      queue_sample(16'sd16383, 16'sd1);
      queue_sample(-16'sd16383, 16'sd16383);
      queue_sample(16'sd12345, -16'sd12345);
      wait_idle();

      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: set_map(1'b1, 9'd256, 9'd256);
            1: set_map(1'b1, 9'd1, 9'd1);
            2: set_map(1'b1, 9'd0, 9'd511);
            3: set_map(1'b1, bhs_pkg::CFG_DIM_BITS'($urandom_range(2, 16)),
                       bhs_pkg::CFG_DIM_BITS'($urandom_range(2, 16)));
            4: set_map(1'b0, 9'd17, 9'd300);
            default: set_map(1'b1, bhs_pkg::CFG_DIM_BITS'($urandom_range(1, 256)),
                             bhs_pkg::CFG_DIM_BITS'($urandom_range(1, 256)));
         endcase
         if (seg < 2) begin
            send_idle_pct = 22;
            recv_idle_pct = 80;
         end else if (seg < 4) begin
            send_idle_pct = 80;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         w = eff_dim(cfg_width);
         h = eff_dim(cfg_height);
         // corner loads count toward the segment's item budget
         seg_start = n_writes + n_samples;
         while (n_writes + n_samples - seg_start < SEGMENT_ITEMS) begin
            if ($urandom_range(9) < 6)
               queue_sample(rand_pos(), rand_pos());
            else if ($urandom_range(1) == 0)
               queue_write($urandom_range(w - 1), $urandom_range(h - 1), 16'($urandom));
            else
               queue_write($urandom_range(255), $urandom_range(255), 16'($urandom));
         end
         wait_idle();
      end

      $display("covered %0d texel writes and %0d samples, %0d elevations checked",
               n_writes, n_samples, n_results);
      $display("over %0d register writes incl. empty map, 1x1, clamped and full 256x256",
               n_csr);
      if (n_fail == 0) begin
         $display("bilinear_height_sample_top_test OK");
      end else begin
         $display("%0d mismatches", n_fail);
         $display("bilinear_height_sample_top_test NOT OK");
      end
      $finish;
   end

endmodule
